// ----- design/assert_macros.svh -----
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, muted while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check that also runs while reset is low.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ppct_pkg.sv -----
package ppct_pkg;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 14;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_DATA_BITS-1:0] RESET_WIDTH  = 14'd1024;
    localparam logic [CFG_DATA_BITS-1:0] RESET_HEIGHT = 14'd768;
    localparam int RESET_POS_X = 512;
    localparam int RESET_POS_Y = 384;

    // status byte bit positions
    localparam int STS_LEFT   = 0;
    localparam int STS_RIGHT  = 1;
    localparam int STS_MIDDLE = 2;
    localparam int STS_SIGN_X = 4;
    localparam int STS_SIGN_Y = 5;

    localparam int NUM_BUTTONS = 3;
    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_MIDDLE = 2'd1;
    localparam logic [1:0] BTN_RIGHT  = 2'd2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    // bit0 left, bit1 middle, bit2 right
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] now;
        logic [NUM_BUTTONS-1:0] changed;
    } t_btn;

endpackage

// ----- design/ppct_if.sv -----
interface ppct_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] delta_x_byte;
    logic [7:0] delta_y_byte;

    modport source (output valid, output status_byte, output delta_x_byte,
                    output delta_y_byte, input ready);
    modport sink (input valid, input status_byte, input delta_x_byte,
                  input delta_y_byte, output ready);
endinterface

interface ppct_evt_if #(
    parameter int COORD_BITS = 13
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            event_kind;
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [1:0]            button_index;
    logic                  last_event;

    modport source (output valid, output event_kind, output cursor_x, output cursor_y,
                    output button_index, output last_event, input ready);
    modport sink (input valid, input event_kind, input cursor_x, input cursor_y,
                  input button_index, input last_event, output ready);
endinterface

// ----- design/ppct_front.sv -----
module ppct_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ppct_pkg::CFG_DATA_BITS-1:0] i_width,
    input  logic [ppct_pkg::CFG_DATA_BITS-1:0] i_height,
    ppct_pkt_if.sink                         i_pkt,
    input  logic                             i_full,
    output logic                             o_push,
    output logic [COORD_BITS-1:0]            o_pos_x,
    output logic [COORD_BITS-1:0]            o_pos_y,
    output ppct_pkg::t_btn                   o_btn
);

    localparam int CW = ppct_pkg::CFG_DATA_BITS;
    // wide enough for position +/- 256 and for the 14-bit screen size
    localparam int W  = (COORD_BITS + 2 > CW + 2) ? COORD_BITS + 2 : CW + 2;
    localparam logic [W-1:0] CAP = W'(1) << COORD_BITS;

    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic [2:0]            r_prev_btn;

    logic [COORD_BITS-1:0] n_pos_x;
    logic [COORD_BITS-1:0] n_pos_y;
    logic [2:0]            now_btn;
    logic signed [W-1:0]   sum_x;
    logic signed [W-1:0]   sum_y;
    logic signed [W-1:0]   dx;
    logic signed [W-1:0]   dy;

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [W-1:0] v,
                                                    input logic [CW-1:0] size);
        logic [W-1:0] lim;
        lim = {{(W-CW){1'b0}}, size};
        if (lim == '0) lim = W'(1);
        if (lim > CAP) lim = CAP;
        if (v < 0) begin
            clamp = '0;
        end else if ($unsigned(v) >= lim) begin
            clamp = COORD_BITS'(lim - W'(1));
        end else begin
            clamp = v[COORD_BITS-1:0];
        end
    endfunction

    assign i_pkt.ready = !i_full;
    assign o_push      = i_pkt.valid && !i_full;

    always_comb begin
        dx = {{(W-8){i_pkt.status_byte[ppct_pkg::STS_SIGN_X]}}, i_pkt.delta_x_byte};
        dy = {{(W-8){i_pkt.status_byte[ppct_pkg::STS_SIGN_Y]}}, i_pkt.delta_y_byte};
        sum_x = $signed({{(W-COORD_BITS){1'b0}}, r_pos_x}) + dx;
        sum_y = $signed({{(W-COORD_BITS){1'b0}}, r_pos_y}) - dy;   // Y is upward positive
        n_pos_x = clamp(sum_x, i_width);
        n_pos_y = clamp(sum_y, i_height);
        now_btn = {i_pkt.status_byte[ppct_pkg::STS_RIGHT],
                   i_pkt.status_byte[ppct_pkg::STS_MIDDLE],
                   i_pkt.status_byte[ppct_pkg::STS_LEFT]};
    end

    assign o_pos_x       = n_pos_x;
    assign o_pos_y       = n_pos_y;
    assign o_btn.now     = now_btn;
    assign o_btn.changed = now_btn ^ r_prev_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x    <= COORD_BITS'(ppct_pkg::RESET_POS_X);
            r_pos_y    <= COORD_BITS'(ppct_pkg::RESET_POS_Y);
            r_prev_btn <= '0;
        end else if (o_push) begin
            r_pos_x    <= n_pos_x;
            r_pos_y    <= n_pos_y;
            r_prev_btn <= now_btn;
        end
    end

endmodule

// ----- design/ppct_fifo.sv -----
`include "assert_macros.svh"

module ppct_fifo #(
    parameter int DATA_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output logic [DATA_BITS-1:0] o_data
);

    localparam int DEPTH = ppct_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]        r_wr_ptr;
    logic [AW-1:0]        r_rd_ptr;
    logic [CNTW-1:0]      r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNTW'(1);
                2'b01:   r_count <= r_count - CNTW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_CLK(a_count_push, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == $past(r_count) + CNTW'(1)), "queue count did not track a push")
    `ASSERT_CLK(a_count_max, i_clk, i_rst_n, r_count <= CNTW'(DEPTH), "queue overfilled")

endmodule

// ----- design/ppct_back.sv -----
`include "assert_macros.svh"

module ppct_back #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  ppct_pkg::t_btn        i_btn,
    output logic                  o_pop,
    ppct_evt_if.source            o_evt
);

    logic                  r_ovalid;
    ppct_pkg::t_kind       r_kind;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [1:0]            r_btn_idx;
    logic                  r_last;
    logic [2:0]            r_pend;
    logic [2:0]            r_now;

    logic       out_free;
    logic [1:0] sel_idx;
    logic [2:0] sel_mask;

    assign out_free = !r_ovalid || o_evt.ready;
    assign o_pop    = out_free && (r_pend == '0) && i_valid;

    // lowest pending button goes first: left, middle, right
    always_comb begin
        if (r_pend[0]) begin
            sel_idx  = ppct_pkg::BTN_LEFT;
            sel_mask = 3'b001;
        end else if (r_pend[1]) begin
            sel_idx  = ppct_pkg::BTN_MIDDLE;
            sel_mask = 3'b010;
        end else begin
            sel_idx  = ppct_pkg::BTN_RIGHT;
            sel_mask = 3'b100;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_pend   <= '0;
        end else if (out_free) begin
            if (r_pend != '0) begin
                r_ovalid  <= 1'b1;
                r_kind    <= ((r_now & sel_mask) != '0) ? ppct_pkg::KIND_DOWN
                                                        : ppct_pkg::KIND_UP;
                r_btn_idx <= sel_idx;
                r_last    <= ((r_pend & ~sel_mask) == '0);
                r_pend    <= r_pend & ~sel_mask;
            end else if (i_valid) begin
                r_ovalid  <= 1'b1;
                r_kind    <= ppct_pkg::KIND_MOVE;
                r_cur_x   <= i_pos_x;
                r_cur_y   <= i_pos_y;
                r_btn_idx <= ppct_pkg::BTN_LEFT;
                r_last    <= (i_btn.changed == '0);
                r_pend    <= i_btn.changed;
                r_now     <= i_btn.now;
            end else begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_evt.valid        = r_ovalid;
    assign o_evt.event_kind   = r_kind;
    assign o_evt.cursor_x     = r_cur_x;
    assign o_evt.cursor_y     = r_cur_y;
    assign o_evt.button_index = r_btn_idx;
    assign o_evt.last_event   = r_last;

    `ASSERT_CLK(a_pend_shown, i_clk, i_rst_n, (r_pend != '0) |-> (r_ovalid && !r_last), "button beats pending without an open packet")
    `ASSERT_CLK(a_no_move_mid, i_clk, i_rst_n, (r_ovalid && o_evt.ready && !r_last) |=> (r_ovalid && r_kind != ppct_pkg::KIND_MOVE), "move beat inside a packet")
    `ASSERT_CLK_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (!r_ovalid && r_pend == '0), "back end not idle after reset")

endmodule

// ----- design/pointer_packet_cursor_tracker_core.sv -----
// An accepted packet passes through the queue into the back end's output register as its move beat.
// Each packet yields a move beat plus one button beat per changed button, 1 to 4 beats;
//   the back end's single output register issues one beat per cycle while the sink is ready;
//   a two-entry queue lets packets be accepted while earlier beats are still draining.
// Reset (synchronous, active low): cursor 512,384, buttons released, screen 1024 x 768,
//   queue and output empty.
module pointer_packet_cursor_tracker_core #(
    parameter int COORD_BITS = 13
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppct_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ppct_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    ppct_pkt_if.sink                            i_pkt,
    ppct_evt_if.source                          o_evt
);

    localparam int JOB_BITS = 2 * COORD_BITS + 2 * ppct_pkg::NUM_BUTTONS;

    logic [ppct_pkg::CFG_DATA_BITS-1:0] r_width;
    logic [ppct_pkg::CFG_DATA_BITS-1:0] r_height;

    logic                  push;
    logic                  full;
    logic                  pop;
    logic                  q_valid;
    logic [COORD_BITS-1:0] f_pos_x;
    logic [COORD_BITS-1:0] f_pos_y;
    ppct_pkg::t_btn        f_btn;
    logic [JOB_BITS-1:0]   q_data;
    logic [COORD_BITS-1:0] b_pos_x;
    logic [COORD_BITS-1:0] b_pos_y;
    ppct_pkg::t_btn        b_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ppct_pkg::RESET_WIDTH;
            r_height <= ppct_pkg::RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ppct_pkg::REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                ppct_pkg::REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppct_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_width (r_width),
        .i_height(r_height),
        .i_pkt   (i_pkt),
        .i_full  (full),
        .o_push  (push),
        .o_pos_x (f_pos_x),
        .o_pos_y (f_pos_y),
        .o_btn   (f_btn)
    );

    ppct_fifo #(.DATA_BITS(JOB_BITS)) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data ({f_pos_x, f_pos_y, f_btn}),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    assign {b_pos_x, b_pos_y, b_btn} = q_data;

    ppct_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_pos_x(b_pos_x),
        .i_pos_y(b_pos_y),
        .i_btn  (b_btn),
        .o_pop  (pop),
        .o_evt  (o_evt)
    );

endmodule
